@@ hw/rtl/ipcs_pkg.sv @@
// Package for the IPv4/UDP checksum engine.
// Holds the word widths, the datagram word positions and the ones'-complement add.
// No dependencies.
package ipcs_pkg;

  localparam int WORD_W = 16;
  localparam int POS_W  = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [POS_W-1:0]  pos_t;

  // Datagram layout, in 16-bit words from the start of the IPv4 header.
  localparam pos_t POS_TOT_LEN   = 4'd1;
  localparam pos_t POS_PROTO     = 4'd4;
  localparam pos_t POS_IP_CSUM   = 4'd5;
  localparam pos_t POS_SRC_ADDR  = 4'd6;
  localparam pos_t IP_HDR_WORDS  = 4'd10;
  localparam pos_t POS_UDP_CSUM  = 4'd13;
  localparam pos_t POS_SAT       = 4'd14;

  localparam int   IP_HDR_BYTES  = 20;
  localparam int   UDP_HDR_BYTES = 8;

  // A datagram whose last word sits before this position lacks part of the UDP header.
  localparam pos_t SHORT_LIMIT = pos_t'(IP_HDR_WORDS + UDP_HDR_BYTES / 2 - 1);

  localparam word_t LEN_ADJUST = word_t'(IP_HDR_BYTES);
  localparam word_t ALL_ONES   = {WORD_W{1'b1}};
  localparam word_t PROTO_MASK = word_t'(8'hFF);
  localparam word_t HIGH_MASK  = word_t'(16'hFF00);

  // Ones'-complement add with end-around carry.
  function automatic word_t oc_add(input word_t a, input word_t b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_W-1:0] + word_t'(s[WORD_W]);
  endfunction

endpackage

@@ hw/rtl/ipv4_udp_checksum_engine_core.sv @@
// IPv4/UDP checksum engine, top level.
// Depends on ipcs_pkg for widths, word positions and the ones'-complement add.
//
// Usage: an IPv4 datagram enters on the in_ channel one big-endian 16-bit word
// per item, the IPv4 header taking words 0 to 9 and the UDP header words 10 to 13.
// in_last marks the final word; with in_odd_tail also set, its low byte is taken
// as zero. For each datagram exactly one item leaves on the out_ channel: the
// complemented IPv4 header sum, the UDP checksum over pseudo header and segment
// (a zero result is sent as 0xFFFF), and a flag that is set when the datagram
// ended before the UDP header was complete. Words other than the last give no item.
// Both channels use valid and stall; an item moves at an edge where valid is high
// and stall is low.
// The last word is taken into the input register when it is accepted, and its
// result is written into the result register once that register can take an
// item. An item is accepted in every cycle in which in_stall is low; each word
// costs one 16-bit end-around add per sum, done between the input register and
// the result register.
// After reset both sums and the word position are zero and no result is held.
// When the receiver stalls, the result register holds its item; the input
// register keeps advancing ordinary words and only halts on a last word that
// cannot yet be written, at which point in_stall is raised.
module ipv4_udp_checksum_engine_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ipcs_pkg::WORD_W-1:0] in_word,
  input  logic                       in_odd_tail,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ipcs_pkg::WORD_W-1:0] out_ip_checksum,
  output logic [ipcs_pkg::WORD_W-1:0] out_udp_checksum,
  output logic                       out_short_packet
);
  import ipcs_pkg::*;

  // Input register.
  logic  s1_valid_r;
  word_t s1_word_r;
  logic  s1_odd_tail_r;
  logic  s1_last_r;

  // Running state of the current datagram.
  pos_t  pos_r, pos_nxt;
  word_t hdr_sum_r, hdr_sum_nxt;
  word_t seg_sum_r, seg_sum_nxt;

  // Result register.
  logic  out_valid_r;
  word_t out_ip_r, out_ip_nxt;
  word_t out_udp_r, out_udp_nxt;
  logic  out_short_r, out_short_nxt;

  logic  out_free;
  logic  s1_go;
  word_t w_eff;
  word_t seg_term;
  logic  hdr_add;
  logic  seg_add;
  word_t hdr_upd;
  word_t seg_upd;

  // The result register can take a new item when it is empty or being emptied.
  assign out_free = !out_valid_r || !out_stall;
  // Ordinary words never wait; only a last word needs room in the result register.
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_go;

  always_comb begin
    // The odd-tail byte is zeroed only on the final word.
    w_eff = (s1_last_r && s1_odd_tail_r) ? (s1_word_r & HIGH_MASK) : s1_word_r;

    hdr_add  = (pos_r < IP_HDR_WORDS) && (pos_r != POS_IP_CSUM);
    seg_add  = 1'b0;
    seg_term = w_eff;
    if (pos_r < IP_HDR_WORDS) begin
      if (pos_r == POS_TOT_LEN) begin
        // Pseudo header length is the IP total length less the header.
        seg_add  = 1'b1;
        seg_term = w_eff - LEN_ADJUST;
      end else if (pos_r == POS_PROTO) begin
        seg_add  = 1'b1;
        seg_term = w_eff & PROTO_MASK;
      end else if (pos_r >= POS_SRC_ADDR) begin
        seg_add  = 1'b1;
      end
    end else begin
      seg_add = (pos_r != POS_UDP_CSUM);
    end

    hdr_upd = hdr_add ? oc_add(hdr_sum_r, w_eff) : hdr_sum_r;
    seg_upd = seg_add ? oc_add(seg_sum_r, seg_term) : seg_sum_r;

    out_ip_nxt    = ~hdr_upd;
    out_udp_nxt   = (~seg_upd == '0) ? ALL_ONES : ~seg_upd;
    out_short_nxt = (pos_r < SHORT_LIMIT);

    pos_nxt     = pos_r;
    hdr_sum_nxt = hdr_sum_r;
    seg_sum_nxt = seg_sum_r;
    if (s1_go) begin
      if (s1_last_r) begin
        pos_nxt     = '0;
        hdr_sum_nxt = '0;
        seg_sum_nxt = '0;
      end else begin
        pos_nxt     = (pos_r < POS_SAT) ? pos_r + pos_t'(1) : POS_SAT;
        hdr_sum_nxt = hdr_upd;
        seg_sum_nxt = seg_upd;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      hdr_sum_r   <= '0;
      seg_sum_r   <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s1_go && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      pos_r     <= pos_nxt;
      hdr_sum_r <= hdr_sum_nxt;
      seg_sum_r <= seg_sum_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_word_r     <= in_word;
      s1_odd_tail_r <= in_odd_tail;
      s1_last_r     <= in_last;
    end
    if (s1_go && s1_last_r) begin
      out_ip_r    <= out_ip_nxt;
      out_udp_r   <= out_udp_nxt;
      out_short_r <= out_short_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ip_checksum  = out_ip_r;
  assign out_udp_checksum = out_udp_r;
  assign out_short_packet = out_short_r;

endmodule
